>>> rtl/core/pbert_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet bit error tester package
// Shared constants, codes, request structs and gain tables for the tester.
// ----------------------------------------------------------------------------
package pbert_pkg;

    // Depth of the reference payload store.
    localparam int MaxPayload = 255;
    // Width of a byte count that can reach MaxPayload.
    localparam int PosW = $clog2(MaxPayload + 1);
    // Width of an index into the reference store.
    localparam int IdxW = $clog2(MaxPayload);
    // Width of the per-packet bit error counter.
    localparam int ErrW = 11;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_END   = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // level / 20 is taken as (level * 3277) >> 16, exact for 10-bit levels.
    localparam logic [11:0] Div20Recip = 12'd3277;
    localparam int          Div20Shift = 16;
    localparam logic [4:0]  Div20      = 5'd20;

    // The linear value overflows 64 bits from decade 17, step 6 upward.
    localparam logic [5:0] SatDecade = 6'd17;
    localparam logic [4:0] SatFrac   = 5'd6;

    typedef struct packed {
        logic            en;
        logic [IdxW-1:0] addr;
        logic [7:0]      data;
    } ref_wr_t;

    typedef struct packed {
        logic            en;
        logic [IdxW-1:0] addr;
    } ref_rd_t;

    // 100 * 10^(f/20), rounded.
    function automatic logic [9:0] frac_gain(input logic [4:0] f);
        logic [9:0] g;
        case (f)
            5'd0:    g = 10'd100;
            5'd1:    g = 10'd112;
            5'd2:    g = 10'd126;
            5'd3:    g = 10'd141;
            5'd4:    g = 10'd158;
            5'd5:    g = 10'd178;
            5'd6:    g = 10'd200;
            5'd7:    g = 10'd224;
            5'd8:    g = 10'd251;
            5'd9:    g = 10'd282;
            5'd10:   g = 10'd316;
            5'd11:   g = 10'd355;
            5'd12:   g = 10'd398;
            5'd13:   g = 10'd447;
            5'd14:   g = 10'd501;
            5'd15:   g = 10'd562;
            5'd16:   g = 10'd631;
            5'd17:   g = 10'd708;
            5'd18:   g = 10'd794;
            5'd19:   g = 10'd891;
            default: g = 10'd0;
        endcase
        return g;
    endfunction

    // 10^d for the decades that do not saturate; larger decades saturate anyway.
    function automatic logic [63:0] decade_gain(input logic [5:0] d);
        logic [63:0] g;
        case (d)
            6'd0:    g = 64'd1;
            6'd1:    g = 64'd10;
            6'd2:    g = 64'd100;
            6'd3:    g = 64'd1000;
            6'd4:    g = 64'd10000;
            6'd5:    g = 64'd100000;
            6'd6:    g = 64'd1000000;
            6'd7:    g = 64'd10000000;
            6'd8:    g = 64'd100000000;
            6'd9:    g = 64'd1000000000;
            6'd10:   g = 64'd10000000000;
            6'd11:   g = 64'd100000000000;
            6'd12:   g = 64'd1000000000000;
            6'd13:   g = 64'd10000000000000;
            6'd14:   g = 64'd100000000000000;
            6'd15:   g = 64'd1000000000000000;
            6'd16:   g = 64'd10000000000000000;
            6'd17:   g = 64'd100000000000000000;
            default: g = '1;
        endcase
        return g;
    endfunction

    function automatic logic [3:0] ones_count(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

endpackage

>>> rtl/core/packet_bit_error_tester_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet bit error tester
// Compares received payload bytes with a stored reference payload and keeps
// good/bad packet counts, a bit error total and a linear RSSI sum.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_ channel (valid/ready). A load item writes one byte of
// the reference payload. Received bytes are compared in order against the
// reference; the item flagged last, or an explicit end item, closes the packet
// and produces one result transfer on the m_ channel carrying the running
// totals, the packet length and a length mismatch flag against expected_length.
// A clear item zeroes the totals and drops the packet in progress.
// Throughput is one item per cycle while the pipeline has room. A result
// appears on the m_ channel once the item that closes the packet has passed
// the reference store read, the bit count, the split 64x10 RSSI gain multiply,
// the partial product merge and the 64-bit accumulate, each in its own stage.
// When the receiver stalls, the result holds and the pipeline behind it fills;
// s_ready drops only when every stage holds an item.
// Reset (synchronous, active low) empties the pipeline, clears all totals and
// expected_length, and marks the reference store as all zero at once.
// expected_length may only be written while no packet result is outstanding.
// ----------------------------------------------------------------------------
module packet_bit_error_tester_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_position,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic [9:0]  s_rssi_level,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_good_packets,
    output logic [15:0] m_bad_packets,
    output logic [31:0] m_bit_errors_total,
    output logic [63:0] m_rssi_linear_sum,
    output logic        m_length_mismatch,
    output logic [7:0]  m_packet_length
);
    import pbert_pkg::*;

    logic [7:0] expected_length_reg;

    // Accept stage
    mode_t           in_mode;
    logic            in_accept;
    logic            in_cmp;
    logic            in_end;
    logic [PosW-1:0] byte_pos_reg;
    logic [PosW-1:0] byte_pos_next;
    logic [PosW-1:0] in_len;
    ref_wr_t         ref_wr;
    ref_rd_t         ref_rd;
    logic [7:0]      ref_byte;

    // Stage 1: compare and count
    logic            s1_valid_reg, s1_cmp_reg, s1_end_reg, s1_clear_reg;
    logic [7:0]      s1_data_reg;
    logic [PosW-1:0] s1_len_reg;
    logic [9:0]      s1_level_reg;
    logic [ErrW-1:0] pkt_err_reg;
    logic [ErrW-1:0] err_sum;
    logic [21:0]     div_prod;
    logic [5:0]      s1_dec;
    logic [4:0]      s1_frac;

    // Stage 2: gain multiply
    logic            s2_valid_reg, s2_end_reg, s2_clear_reg;
    logic [ErrW-1:0] s2_err_reg;
    logic [PosW-1:0] s2_len_reg;
    logic [5:0]      s2_dec_reg;
    logic [4:0]      s2_frac_reg;
    logic [63:0]     dec_gain;
    logic [9:0]      fr_gain;

    // Stage 3: partial product merge
    logic            s3_valid_reg, s3_end_reg, s3_clear_reg, s3_sat_reg;
    logic [ErrW-1:0] s3_err_reg;
    logic [PosW-1:0] s3_len_reg;
    logic [41:0]     s3_lo_reg, s3_hi_reg;
    logic [63:0]     lin_value;

    // Stage 4: totals update
    logic            s4_valid_reg, s4_end_reg, s4_clear_reg;
    logic [ErrW-1:0] s4_err_reg;
    logic [PosW-1:0] s4_len_reg;
    logic [63:0]     s4_lin_reg;

    // Totals and result register
    logic            m_valid_reg;
    logic [15:0]     good_total_reg, bad_total_reg;
    logic [31:0]     error_total_reg;
    logic [63:0]     rssi_sum_reg;
    logic            mismatch_reg;
    logic [7:0]      length_reg;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // Each stage moves when it is empty or the stage after it moves.
    assign rdy5 = !m_valid_reg || m_ready;
    assign rdy4 = !s4_valid_reg || rdy5;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;

    assign s_ready   = rdy1;
    assign in_accept = s_valid && s_ready;
    assign in_mode   = mode_t'(s_mode);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_length_reg <= '0;
        end else if (cfg_wr_en) begin
            expected_length_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: store access and byte position tracking.
    // ------------------------------------------------------------------
    always_comb begin
        in_cmp        = (in_mode == MODE_BYTE) && (byte_pos_reg < PosW'(MaxPayload));
        in_end        = ((in_mode == MODE_BYTE) && s_last_byte) || (in_mode == MODE_END);
        in_len        = byte_pos_reg + PosW'(in_cmp);
        byte_pos_next = byte_pos_reg;
        case (in_mode)
            MODE_LOAD:  byte_pos_next = byte_pos_reg;
            MODE_BYTE:  byte_pos_next = s_last_byte ? '0 : in_len;
            MODE_END:   byte_pos_next = '0;
            MODE_CLEAR: byte_pos_next = '0;
            default:    byte_pos_next = byte_pos_reg;
        endcase
    end

    assign ref_wr.en   = in_accept && (in_mode == MODE_LOAD)
                         && (s_position < 8'(MaxPayload));
    assign ref_wr.addr = s_position[IdxW-1:0];
    assign ref_wr.data = s_data_byte;
    assign ref_rd.en   = in_accept && in_cmp;
    assign ref_rd.addr = byte_pos_reg[IdxW-1:0];

    pbert_ref_store u_ref_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_req  (ref_wr),
        .rd_req  (ref_rd),
        .rd_data (ref_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                byte_pos_reg <= byte_pos_next;
            end
            if (rdy1) begin
                s1_valid_reg <= in_accept && (in_mode != MODE_LOAD);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_cmp_reg   <= in_cmp;
            s1_end_reg   <= in_end;
            s1_clear_reg <= (in_mode == MODE_CLEAR);
            s1_data_reg  <= s_data_byte;
            s1_len_reg   <= in_len;
            s1_level_reg <= s_rssi_level;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: bit errors of the byte and RSSI decade split.
    // ------------------------------------------------------------------
    always_comb begin
        err_sum  = pkt_err_reg
                   + (s1_cmp_reg ? ErrW'(ones_count(s1_data_reg ^ ref_byte)) : '0);
        div_prod = 22'(s1_level_reg) * 22'(Div20Recip);
        s1_dec   = div_prod[Div20Shift +: 6];
        s1_frac  = 5'(s1_level_reg - 10'(s1_dec) * 10'(Div20));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_err_reg  <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_valid_reg && rdy2) begin
                pkt_err_reg <= (s1_end_reg || s1_clear_reg) ? '0 : err_sum;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg && (s1_end_reg || s1_clear_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_end_reg   <= s1_end_reg;
            s2_clear_reg <= s1_clear_reg;
            s2_err_reg   <= err_sum;
            s2_len_reg   <= s1_len_reg;
            s2_dec_reg   <= s1_dec;
            s2_frac_reg  <= s1_frac;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: 10^decade times the step gain, as two 32x10 products.
    // ------------------------------------------------------------------
    assign dec_gain = decade_gain(s2_dec_reg);
    assign fr_gain  = frac_gain(s2_frac_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (rdy3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_end_reg   <= s2_end_reg;
            s3_clear_reg <= s2_clear_reg;
            s3_err_reg   <= s2_err_reg;
            s3_len_reg   <= s2_len_reg;
            s3_lo_reg    <= 42'(dec_gain[31:0]) * 42'(fr_gain);
            s3_hi_reg    <= 42'(dec_gain[63:32]) * 42'(fr_gain);
            s3_sat_reg   <= (s2_dec_reg > SatDecade)
                            || ((s2_dec_reg == SatDecade) && (s2_frac_reg >= SatFrac));
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: merge partial products, saturating on overflow.
    // ------------------------------------------------------------------
    assign lin_value = s3_sat_reg ? '1 : (64'(s3_lo_reg) + {s3_hi_reg[31:0], 32'h0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (rdy4) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            s4_end_reg   <= s3_end_reg;
            s4_clear_reg <= s3_clear_reg;
            s4_err_reg   <= s3_err_reg;
            s4_len_reg   <= s3_len_reg;
            s4_lin_reg   <= lin_value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: totals. The totals double as the result payload, so they
    // only change when the result register is free or being taken.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            good_total_reg  <= '0;
            bad_total_reg   <= '0;
            error_total_reg <= '0;
            rssi_sum_reg    <= '0;
        end else if (rdy5) begin
            m_valid_reg <= s4_valid_reg && s4_end_reg;
            if (s4_valid_reg && s4_clear_reg) begin
                good_total_reg  <= '0;
                bad_total_reg   <= '0;
                error_total_reg <= '0;
                rssi_sum_reg    <= '0;
            end else if (s4_valid_reg && s4_end_reg) begin
                if (s4_err_reg != '0) begin
                    bad_total_reg <= bad_total_reg + 16'd1;
                end else begin
                    good_total_reg <= good_total_reg + 16'd1;
                end
                error_total_reg <= error_total_reg + 32'(s4_err_reg);
                rssi_sum_reg    <= rssi_sum_reg + s4_lin_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5 && s4_valid_reg && s4_end_reg) begin
            length_reg   <= 8'(s4_len_reg);
            mismatch_reg <= (8'(s4_len_reg) != expected_length_reg);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_good_packets     = good_total_reg;
    assign m_bad_packets      = bad_total_reg;
    assign m_bit_errors_total = error_total_reg;
    assign m_rssi_linear_sum  = rssi_sum_reg;
    assign m_length_mismatch  = mismatch_reg;
    assign m_packet_length    = length_reg;

endmodule

>>> rtl/core/pbert_ref_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference payload store
// Single-port write, single-port read memory; read data is registered and
// arrives in the cycle after the read request. Per-entry written flags make never-written entries read as zero.
// ----------------------------------------------------------------------------
module pbert_ref_store (
    input  logic              aclk,
    input  logic              aresetn,
    input  pbert_pkg::ref_wr_t wr_req,
    input  pbert_pkg::ref_rd_t rd_req,
    output logic [7:0]        rd_data
);
    import pbert_pkg::*;

    logic [7:0]            mem [0:MaxPayload-1];
    logic [7:0]            mem_q_reg;
    logic [MaxPayload-1:0] written_reg;
    logic                  hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en) begin
            mem_q_reg <= mem[rd_req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end else begin
            if (wr_req.en) begin
                written_reg[wr_req.addr] <= 1'b1;
            end
            if (rd_req.en) begin
                hit_reg <= written_reg[rd_req.addr];
            end
        end
    end

    assign rd_data = hit_reg ? mem_q_reg : 8'h00;

endmodule

>>> rtl/core/pbert_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet bit error tester checker
// Port-level properties of the tester, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pbert_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_good_packets,
    input logic [15:0] m_bad_packets,
    input logic [31:0] m_bit_errors_total,
    input logic [63:0] m_rssi_linear_sum,
    input logic        m_length_mismatch,
    input logic [7:0]  m_packet_length
);

    // Reset empties the result register.
    a_reset_no_result: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Reset empties the pipeline, so an item can be taken right away.
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // The input is only held off while a result waits on the receiver.
    a_stall_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input blocked without a stalled result");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_good_packets)
            && $stable(m_bad_packets) && $stable(m_bit_errors_total)
            && $stable(m_rssi_linear_sum) && $stable(m_length_mismatch)
            && $stable(m_packet_length))
        else $error("stalled result changed");

endmodule

bind packet_bit_error_tester_unit pbert_checker u_pbert_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_good_packets     (m_good_packets),
    .m_bad_packets      (m_bad_packets),
    .m_bit_errors_total (m_bit_errors_total),
    .m_rssi_linear_sum  (m_rssi_linear_sum),
    .m_length_mismatch  (m_length_mismatch),
    .m_packet_length    (m_packet_length)
);

>>> test/packet_bit_error_tester_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet bit error tester testbench
// Streams reference loads, received bytes, packet ends and clears into the
// tester and keeps its own running copy of the totals. Each result transfer is
// compared field by field with the predicted totals. Idle bursts on both
// channels, a long result stall and several expected_length settings are
// included.
// ----------------------------------------------------------------------------
module packet_bit_error_tester_unit_tb;
    import pbert_pkg::*;

    localparam int HalfPeriod = 5;
    // Input transfers to send before the closing full-rate part.
    localparam int ItemTarget = 1400;
    // Length of the one long result stall, in cycles.
    localparam int LongHold = 80;
    // Cycles without any transfer before the run is declared hung.
    localparam int QuietLimit = 2000;
    // Settling time after the last expected result.
    localparam int TailCycles = 10;
    localparam logic [63:0] LinearMax = '1;

    // 100 * 10^(k/20), element k of the vector.
    localparam logic [19:0][9:0] StepGain = {
        10'd891, 10'd794, 10'd708, 10'd631, 10'd562, 10'd501, 10'd447, 10'd398,
        10'd355, 10'd316, 10'd282, 10'd251, 10'd224, 10'd200, 10'd178, 10'd158,
        10'd141, 10'd126, 10'd112, 10'd100
    };

    typedef struct packed {
        logic [15:0] good;
        logic [15:0] bad;
        logic [31:0] errors;
        logic [63:0] rssi_sum;
        logic        mismatch;
        logic [7:0]  length;
    } tally_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = MODE_LOAD;
    logic [7:0]  s_position = '0;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic [9:0]  s_rssi_level = '0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [15:0] m_good_packets;
    logic [15:0] m_bad_packets;
    logic [31:0] m_bit_errors_total;
    logic [63:0] m_rssi_linear_sum;
    logic        m_length_mismatch;
    logic [7:0]  m_packet_length;

    // Shadow of the tester state, advanced once per accepted input transfer.
    logic [7:0]  ref_image [MaxPayload];
    logic [7:0]  rx_count = '0;
    logic [10:0] rx_error_bits = '0;
    logic [15:0] good_count = '0;
    logic [15:0] bad_count = '0;
    logic [31:0] error_sum = '0;
    logic [63:0] rssi_accum = '0;
    logic [7:0]  length_setting = '0;

    // Predicted totals waiting for their result transfer, oldest first.
    tally_t expected_tallies[$];

    int unsigned idle_odds = 0;
    bit          hold_request = 1'b0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_flags_seen = 0;
    int unsigned saturated_terms = 0;
    int unsigned bytes_past_store = 0;
    int unsigned config_writes = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count = 0;

    packet_bit_error_tester_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_position         (s_position),
        .s_data_byte        (s_data_byte),
        .s_last_byte        (s_last_byte),
        .s_rssi_level       (s_rssi_level),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_good_packets     (m_good_packets),
        .m_bad_packets      (m_bad_packets),
        .m_bit_errors_total (m_bit_errors_total),
        .m_rssi_linear_sum  (m_rssi_linear_sum),
        .m_length_mismatch  (m_length_mismatch),
        .m_packet_length    (m_packet_length)
    );

    always begin
        #HalfPeriod aclk = 1'b1;
        #HalfPeriod aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Linear RSSI term: 10^(level/20) times the step gain, clamped to 64 bits.
    // The product is built in 128 bits and clamped after every factor, so a
    // clamped value stays clamped.
    function automatic logic [63:0] rssi_linear(input logic [9:0] level);
        logic [127:0] acc;
        acc = 128'd1;
        for (int d = 0; d < int'(level) / 20; d++) begin
            acc = acc * 10;
            if (acc > {64'd0, LinearMax}) acc = {64'd0, LinearMax};
        end
        acc = acc * StepGain[level % 20];
        if (acc > {64'd0, LinearMax}) acc = {64'd0, LinearMax};
        return acc[63:0];
    endfunction

    // Closes the packet in progress: updates the totals, snapshots them for the
    // result and starts an empty packet.
    function automatic tally_t close_packet(input logic [9:0] level);
        tally_t t;
        logic [63:0] term;
        term = rssi_linear(level);
        if (term == LinearMax) saturated_terms++;
        if (rx_error_bits != 0) bad_count++;
        else good_count++;
        error_sum += 32'(rx_error_bits);
        rssi_accum += term;
        t.good = good_count;
        t.bad = bad_count;
        t.errors = error_sum;
        t.rssi_sum = rssi_accum;
        t.mismatch = (rx_count != length_setting);
        t.length = rx_count;
        rx_count = '0;
        rx_error_bits = '0;
        return t;
    endfunction

    // Applies one accepted input transfer to the shadow state. Returns 1 when
    // the transfer closes a packet, with the totals it must report in t.
    function automatic bit predict_tally(input mode_t mode, input logic [7:0] pos,
                                         input logic [7:0] data, input logic last,
                                         input logic [9:0] level, output tally_t t);
        bit produced;
        produced = 1'b0;
        t = '0;
        case (mode)
            MODE_LOAD: begin
                // Loads aimed past the store are dropped.
                if (pos < MaxPayload) ref_image[pos] = data;
            end
            MODE_BYTE: begin
                // Bytes past the store are not compared, but last still closes.
                if (rx_count < MaxPayload) begin
                    rx_error_bits += 11'($countones(data ^ ref_image[rx_count]));
                    rx_count++;
                end else begin
                    bytes_past_store++;
                end
                if (last) begin
                    t = close_packet(level);
                    produced = 1'b1;
                end
            end
            MODE_END: begin
                t = close_packet(level);
                produced = 1'b1;
            end
            default: begin
                // Clear keeps the reference store and the length register.
                good_count = '0;
                bad_count = '0;
                error_sum = '0;
                rssi_accum = '0;
                rx_count = '0;
                rx_error_bits = '0;
            end
        endcase
        return produced;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one input transfer and blocks until it is accepted. An idle burst
    // with valid low may come first. Valid is left high after acceptance; the
    // next call or wait_drained replaces it at the following falling edge,
    // always before the next rising edge.
    task automatic send_item(input mode_t mode, input logic [7:0] pos, input logic [7:0] data,
                             input logic last, input logic [9:0] level);
        tally_t t;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_position   <= pos;
        s_data_byte  <= data;
        s_last_byte  <= last;
        s_rssi_level <= level;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (predict_tally(mode, pos, data, last, level, t)) expected_tallies.push_back(t);
    endtask

    // Fields that a mode does not use are filled with random values.
    task automatic send_load(input logic [7:0] pos, input logic [7:0] data);
        send_item(MODE_LOAD, pos, data, 1'($urandom), 10'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last, input logic [9:0] level);
        send_item(MODE_BYTE, 8'($urandom), data, last, level);
    endtask

    task automatic send_end(input logic [9:0] level);
        send_item(MODE_END, 8'($urandom), 8'($urandom), 1'($urandom), level);
    endtask

    task automatic send_clear();
        send_item(MODE_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), 10'($urandom));
    endtask

    // Most levels stay below the point where the linear term clamps.
    function automatic logic [9:0] random_level();
        return ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 345));
    endfunction

    // Sends a packet of count bytes built from the reference image, with a bit
    // error pattern in about one byte out of four. The packet is closed by the
    // last mark on its final byte, or by an end transfer.
    task automatic send_packet(input int unsigned count, input bit end_on_last);
        logic [7:0] flips;
        logic [7:0] base;
        for (int unsigned i = 0; i < count; i++) begin
            flips = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
            base = (rx_count < MaxPayload) ? ref_image[rx_count] : 8'($urandom);
            send_byte(base ^ flips, end_on_last && (i == count - 1), random_level());
        end
        if (!end_on_last || count == 0) send_end(random_level());
    endtask

    // Drops valid and waits until every predicted result has been checked,
    // plus the pipeline depth, so that nothing is still in flight.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);
    endtask

    // Register write; only called with the tester drained.
    task automatic write_length(input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'($urandom);
        length_setting = value;
        config_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Ready is set at falling edges. A hold request from the tests stalls the
    // result channel for the long hold set by LongHold; otherwise idle bursts
    // of random length start at random while idle_odds is nonzero.
    initial begin : result_sink
        int unsigned hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold = LongHold;
            end else if (hold == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                hold = $urandom_range(1, 10);
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Every accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        tally_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tallies.size() == 0) begin
                fail_count++;
                $display("%0t: result transfer with none expected, expected nothing, actual %0d",
                         $time, m_packet_length);
            end else begin
                want = expected_tallies.pop_front();
                results_checked++;
                if (m_length_mismatch === 1'b1) mismatch_flags_seen++;
                check_field("good_packets", 64'(want.good), 64'(m_good_packets));
                check_field("bad_packets", 64'(want.bad), 64'(m_bad_packets));
                check_field("bit_errors_total", 64'(want.errors), 64'(m_bit_errors_total));
                check_field("rssi_linear_sum", want.rssi_sum, m_rssi_linear_sum);
                check_field("length_mismatch", 64'(want.mismatch), 64'(m_length_mismatch));
                check_field("packet_length", 64'(want.length), 64'(m_packet_length));
            end
        end
    end

    // Hang detection: any transfer on either channel restarts the count.
    always @(posedge aclk) begin
        if (s_valid && !s_ready) input_stall_cycles++;
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles == QuietLimit) begin
            $display("%0t: no transfer in %0d cycles, %0d results outstanding",
                     $time, QuietLimit, expected_tallies.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked items run with the reset value of expected_length, which is
    // zero, so only the empty packets match it.
    task automatic test_directed_cases();
        idle_odds = 4;
        // An empty packet right after reset is good and has the lowest RSSI term.
        send_end(10'd0);
        // Reference bytes at both ends of the store; a load past the store is
        // dropped.
        send_load(8'd0, 8'hFF);
        send_load(8'd1, 8'h00);
        send_load(8'd254, 8'hA5);
        send_load(8'd255, 8'h5A);
        // Every bit wrong in both bytes; the highest level clamps the term.
        send_byte(8'h00, 1'b0, 10'd0);
        send_byte(8'hFF, 1'b1, 10'd1023);
        // A clean two-byte packet closed by an end transfer; a second clamped
        // term makes the 64-bit sum wrap.
        send_byte(8'hFF, 1'b0, 10'd7);
        send_byte(8'h00, 1'b0, 10'd9);
        send_end(10'd1023);
        // The largest level that does not clamp, the smallest that does, and
        // the step from one decade to the next.
        send_end(10'd345);
        send_end(10'd346);
        send_end(10'd19);
        send_end(10'd20);
        // A load immediately followed by the byte that is compared against it.
        send_load(8'd0, 8'h3C);
        send_byte(8'h3C, 1'b1, 10'd500);
        // A clear with a packet in progress drops the packet and the totals.
        send_byte(8'h00, 1'b0, 10'd1);
        send_byte(8'h11, 1'b0, 10'd2);
        send_clear();
        send_byte(8'h3C, 1'b1, 10'd1022);
        send_end(10'd1023);
    endtask

    // Small expected lengths, with packets one byte short, exact and one over.
    task automatic test_length_register();
        logic [7:0] lengths [4];
        lengths = '{8'd1, 8'd0, 8'd2, 8'($urandom_range(3, 12))};
        idle_odds = 5;
        foreach (lengths[k]) begin
            wait_drained();
            write_length(lengths[k]);
            for (int n = int'(lengths[k]) - 1; n <= int'(lengths[k]) + 1; n++) begin
                if (n >= 0) send_packet(n, n % 2 == 0);
            end
        end
    endtask

    // The whole store is loaded and one packet runs two bytes past it; the
    // last mark on the final byte still closes the packet at length 255.
    task automatic test_long_packets();
        idle_odds = 8;
        wait_drained();
        write_length(8'd255);
        for (int i = 0; i < MaxPayload; i++) send_load(8'(i), 8'($urandom));
        send_packet(MaxPayload + 2, 1'b1);
    endtask

    // The receiver holds off for a long stretch while packet ends keep coming,
    // so the pipeline fills and input ready drops. The sender then pauses
    // until every result has come back.
    task automatic test_result_stall();
        idle_odds = 0;
        wait_drained();
        hold_request = 1'b1;
        repeat (40) begin
            if ($urandom_range(0, 1)) send_end(random_level());
            else send_byte(8'($urandom), 1'b1, random_level());
        end
        wait_drained();
    endtask

    // Phases of well-formed traffic: the length register is set, a reference
    // of random length is loaded, and a few packets follow. Stray loads,
    // random items and packets cut short by a clear are mixed in.
    task automatic test_random_traffic();
        int unsigned len;
        logic [7:0]  setting;
        while (items_sent < ItemTarget) begin
            case ($urandom_range(0, 3))
                0: idle_odds = 0;
                1: idle_odds = 3;
                2: idle_odds = 6;
                default: idle_odds = 12;
            endcase
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: setting = 8'($urandom);
                1: setting = 8'(len + 1);
                default: setting = 8'(len);
            endcase
            wait_drained();
            write_length(setting);
            for (int unsigned i = 0; i < len; i++) begin
                if ($urandom_range(0, 7) == 0) send_load(8'($urandom), 8'($urandom));
                send_load(8'(i), 8'($urandom));
            end
            repeat ($urandom_range(2, 5)) begin
                case ($urandom_range(0, 15))
                    0: begin
                        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, random_level());
                        send_clear();
                    end
                    1: send_item(mode_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                                 1'($urandom), random_level());
                    default: ;
                endcase
                send_packet($urandom_range(0, 1) ? len : $urandom_range(0, len + 2),
                            $urandom_range(0, 3) != 0);
            end
        end
    endtask

    // Closing part with no idling on either side.
    task automatic test_full_rate();
        idle_odds = 0;
        wait_drained();
        repeat (8) send_packet($urandom_range(0, 6), $urandom_range(0, 1));
    endtask

    initial begin : stimulus
        foreach (ref_image[i]) ref_image[i] = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_length_register();
        test_long_packets();
        test_result_stall();
        test_random_traffic();
        test_full_rate();
        wait_drained();

        $display("Run covered %0d input transfers and %0d packet results, %0d with a length mismatch.",
                 items_sent, results_checked, mismatch_flags_seen);
        $display("It saw %0d clamped RSSI terms, %0d bytes past the store, %0d length writes and %0d back-pressure cycles.",
                 saturated_terms, bytes_past_store, config_writes, input_stall_cycles);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
